[sv/vtd_pkg.sv]
// Shared types and constants for the vertex triple deduplication block.
`default_nettype none

package vtd_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_INDEX_WIDTH = 16;
    localparam int IDX_FIELD_W     = 16;
    localparam int SLOT_OUT_W      = 8;

    typedef struct packed {
        logic                   mesh_start;
        logic [IDX_FIELD_W-1:0] position_index;
        logic [IDX_FIELD_W-1:0] texcoord_index;
        logic [IDX_FIELD_W-1:0] normal_index;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] vertex_slot;
        logic                  is_new;
        logic                  table_full;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic done;
        logic is_new;
    } t_tok_flags;

endpackage

`default_nettype wire

[sv/vertex_triple_dedup_top.sv]
// Top level of the vertex triple deduplication block: cell chain, entry count and result register.
//
// Channel  | Direction | Handshake         | Payload
// item in  | input     | start / busy      | i_item  (t_in_item)
// result   | output    | o_done strobe     | o_result (t_out_item)
//
// An item is accepted when start is high and busy is low. Its lookup token walks the row of
// TABLE_DEPTH cells, one cell per cycle. The result strobe rises at the same edge at which
// busy falls, and the result is taken at the next edge; a new item is not accepted until the
// previous one has left the last cell.
// Reset empties the entry count, the busy and done flags and the token flags; no clearing pass is needed.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

module vertex_triple_dedup_top
    import vtd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_item i_item,
    output logic          busy,
    output logic          o_done,
    output t_out_item     o_result
);

    localparam int IW = (INDEX_WIDTH < IDX_FIELD_W) ? INDEX_WIDTH : IDX_FIELD_W;
    localparam int KW = 3 * IW;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(TABLE_DEPTH);

    t_tok_flags    c_flags [TABLE_DEPTH+1];
    logic [CW-1:0] c_rem   [TABLE_DEPTH+1];
    logic [SW-1:0] c_slot  [TABLE_DEPTH+1];
    logic [KW-1:0] c_key   [TABLE_DEPTH+1];

    logic          r_busy;
    logic [CW-1:0] r_used;
    logic          r_done;
    t_out_item     r_result;
    t_out_item     n_result;
    logic          accept;
    t_tok_flags    tail;

    assign accept = start && !r_busy;

    always_comb begin
        c_flags[0].valid  = accept;
        c_flags[0].done   = 1'b0;
        c_flags[0].is_new = 1'b0;
        c_rem[0]          = i_item.mesh_start ? '0 : r_used;
        c_slot[0]         = '0;
        c_key[0]          = {i_item.position_index[IW-1:0],
                             i_item.texcoord_index[IW-1:0],
                             i_item.normal_index[IW-1:0]};
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vtd_cell #(
            .KW   (KW),
            .CW   (CW),
            .SW   (SW),
            .SLOT (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flags (c_flags[g]),
            .i_rem   (c_rem[g]),
            .i_slot  (c_slot[g]),
            .i_key   (c_key[g]),
            .o_flags (c_flags[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_slot  (c_slot[g+1]),
            .o_key   (c_key[g+1])
        );
    end

    always_comb begin
        tail = c_flags[TABLE_DEPTH];
        n_result.vertex_slot = tail.done ? SLOT_OUT_W'(c_slot[TABLE_DEPTH]) : '0;
        n_result.is_new      = tail.is_new;
        n_result.table_full  = !tail.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_used <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= tail.valid;
            if (accept) begin
                r_busy <= 1'b1;
                if (i_item.mesh_start) begin
                    r_used <= '0;
                end
            end else if (tail.valid) begin
                r_busy <= 1'b0;
                if (tail.is_new) begin
                    r_used <= r_used + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.valid) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

[sv/vtd_cell.sv]
// One table cell: holds one stored triple and passes the lookup token to its neighbor.
`default_nettype none

module vtd_cell
    import vtd_pkg::*;
#(
    parameter int KW   = 48,
    parameter int CW   = 9,
    parameter int SW   = 8,
    parameter int SLOT = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_tok_flags  i_flags,
    input  wire logic [CW-1:0] i_rem,
    input  wire logic [SW-1:0] i_slot,
    input  wire logic [KW-1:0] i_key,
    output t_tok_flags       o_flags,
    output logic [CW-1:0]    o_rem,
    output logic [SW-1:0]    o_slot,
    output logic [KW-1:0]    o_key
);

    logic [KW-1:0] r_key;
    t_tok_flags    r_flags;
    t_tok_flags    n_flags;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] n_rem;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] n_slot;
    logic [KW-1:0] r_tok_key;
    logic          live;
    logic          hit;
    logic          append;

    always_comb begin
        live    = i_flags.valid && !i_flags.done;
        hit     = live && (i_rem != '0) && (r_key == i_key);
        append  = live && (i_rem == '0);
        n_flags.valid  = i_flags.valid;
        n_flags.done   = i_flags.done || hit || append;
        n_flags.is_new = i_flags.is_new || append;
        n_rem   = (live && (i_rem != '0)) ? i_rem - CW'(1) : i_rem;
        n_slot  = (hit || append) ? SW'(SLOT) : i_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_slot    <= n_slot;
        r_tok_key <= i_key;
        if (append) begin
            r_key <= i_key;
        end
    end

    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_slot  = r_slot;
    assign o_key   = r_tok_key;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for vertex_triple_dedup_top with a corner-to-slot scoreboard.
`default_nettype none

module tb_top;
    import vtd_pkg::*;

    localparam int MAX_GAP    = 300;
    localparam int IDLE_LIMIT = 8 * (DEF_TABLE_DEPTH + 1) + 2 * MAX_GAP;
    localparam int N_CORNERS  = 1150;

    localparam int IDX_FULL    = 0;
    localparam int IDX_NARROW  = 1;
    localparam int IDX_EXTREME = 2;

    class slot_scoreboard;
        logic [3*IDX_FIELD_W-1:0] stored_triples[DEF_TABLE_DEPTH];
        int unsigned              entries_used = 0;
        t_out_item                expected_slots[$];
        int                       n_errors = 0;

        function void note_corner(t_in_item c);
            logic [3*IDX_FIELD_W-1:0] key;
            t_out_item                r;
            bit                       hit;
            hit = 1'b0;
            r   = '0;
            key = {c.position_index, c.texcoord_index, c.normal_index};
            if (c.mesh_start) begin
                entries_used = 0;
            end
            for (int i = 0; i < entries_used; i++) begin
                if (!hit && stored_triples[i] == key) begin
                    hit           = 1'b1;
                    r.vertex_slot = i[SLOT_OUT_W-1:0];
                end
            end
            if (!hit) begin
                if (entries_used < DEF_TABLE_DEPTH) begin
                    stored_triples[entries_used] = key;
                    r.vertex_slot = entries_used[SLOT_OUT_W-1:0];
                    r.is_new      = 1'b1;
                    entries_used++;
                end else begin
                    r.table_full = 1'b1;
                end
            end
            expected_slots = {expected_slots, r};
        endfunction

        function void check_slot(t_out_item got);
            t_out_item want;
            if (expected_slots.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                n_errors++;
                return;
            end
            want = expected_slots.pop_front();
            if (got.vertex_slot !== want.vertex_slot) begin
                $display("%0t: vertex_slot expected %0d got %0d", $time, want.vertex_slot,
                         got.vertex_slot);
                n_errors++;
            end
            if (got.is_new !== want.is_new) begin
                $display("%0t: is_new expected %b got %b", $time, want.is_new, got.is_new);
                n_errors++;
            end
            if (got.table_full !== want.table_full) begin
                $display("%0t: table_full expected %b got %b", $time, want.table_full,
                         got.table_full);
                n_errors++;
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    slot_scoreboard           sb = new();
    logic [3*IDX_FIELD_W-1:0] mesh_corners[$];
    int                       n_sent     = 0;
    int                       burst_left = 0;
    int                       idle_cycles = 0;

    vertex_triple_dedup_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            sb.check_slot(o_result);
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_in_item make_corner(logic ms, logic [15:0] p, logic [15:0] t,
                                             logic [15:0] n);
        t_in_item c;
        c.mesh_start     = ms;
        c.position_index = p;
        c.texcoord_index = t;
        c.normal_index   = n;
        return c;
    endfunction

    function automatic logic [15:0] rand_index(int mode);
        logic [15:0] picks[5];
        picks = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
        case (mode)
            IDX_NARROW:  return 16'($urandom_range(0, 3));
            IDX_EXTREME: return picks[$urandom_range(0, 4)];
            default:     return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_item known_corner(logic ms);
        logic [3*IDX_FIELD_W-1:0] key;
        key = mesh_corners[$urandom_range(0, mesh_corners.size() - 1)];
        return make_corner(ms, key[47:32], key[31:16], key[15:0]);
    endfunction

    task automatic send_corner(input t_in_item c);
        int                       gap;
        logic [3*IDX_FIELD_W-1:0] key;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_item <= c;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_corner(c);
        if (c.mesh_start) begin
            mesh_corners.delete();
        end
        key          = {c.position_index, c.texcoord_index, c.normal_index};
        mesh_corners = {mesh_corners, key};
        n_sent++;
    endtask

    task automatic run_mesh(int len);
        int       fresh_pct;
        int       mode;
        logic     ms;
        t_in_item c;
        fresh_pct = $urandom_range(20, 80);
        mode      = $urandom_range(IDX_FULL, IDX_EXTREME);
        for (int k = 0; k < len; k++) begin
            ms = (k == 0) || ($urandom_range(0, 19) == 0);
            if (!ms && mesh_corners.size() != 0 && $urandom_range(0, 99) >= fresh_pct) begin
                c = known_corner(1'b0);
            end else begin
                c = make_corner(ms, rand_index(mode), rand_index(mode), rand_index(mode));
            end
            send_corner(c);
        end
    endtask

    task automatic fill_mesh(int extra);
        for (int k = 0; k < DEF_TABLE_DEPTH; k++) begin
            send_corner(make_corner(k == 0, 16'(k), rand_index(IDX_FULL),
                                    rand_index(IDX_FULL)));
        end
        for (int k = 0; k < extra; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_corner(known_corner(1'b0));
            end else begin
                send_corner(make_corner(1'b0, 16'($urandom_range(DEF_TABLE_DEPTH, 65535)),
                                        rand_index(IDX_FULL), rand_index(IDX_FULL)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_corner(make_corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
        send_corner(make_corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
        send_corner(make_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(make_corner(1'b0, 16'hFFFF, 16'h0000, 16'h0000));
        send_corner(make_corner(1'b0, 16'h0000, 16'hFFFF, 16'h0000));
        send_corner(make_corner(1'b0, 16'h0000, 16'h0000, 16'hFFFF));
        send_corner(make_corner(1'b0, 16'h0000, 16'h0000, 16'hFFFF));
        send_corner(make_corner(1'b0, 16'h1234, 16'h5678, 16'h9ABC));
        send_corner(make_corner(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_corner(make_corner(1'b0, 16'h5555, 16'hAAAA, 16'h5555));
        send_corner(make_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(make_corner(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(make_corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
        send_corner(make_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(make_corner(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(make_corner(1'b1, 16'h0000, 16'h0000, 16'h0000));
        send_corner(make_corner(1'b1, 16'h0000, 16'h0000, 16'h0000));
        send_corner(make_corner(1'b0, 16'h8000, 16'h8000, 16'h8000));
        send_corner(make_corner(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_corner(make_corner(1'b0, 16'h8000, 16'h8000, 16'h8000));

        while (n_sent < 400) run_mesh($urandom_range(1, 40));
        fill_mesh(30);
        while (n_sent < 800) run_mesh($urandom_range(1, 40));
        fill_mesh(30);
        while (n_sent < N_CORNERS) run_mesh($urandom_range(1, 40));
        start <= 1'b0;

        while (sb.expected_slots.size() != 0) @(posedge i_clk);
        repeat (DEF_TABLE_DEPTH + 8) @(posedge i_clk);
        if (sb.expected_slots.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.expected_slots.size());
            sb.n_errors++;
        end
        if (sb.n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/vtd_pkg.sv
sv/vtd_cell.sv
sv/vertex_triple_dedup_top.sv
tb/sv/tb_top.sv
